// File: rtl/core/deq_pkg.sv
// Shared types, codes and sizes for the double-ended queue.
package deq_pkg;

	localparam int unsigned DEPTH_DEFAULT = 64;
	localparam int unsigned CMD_W         = 3;
	localparam int unsigned WORD_W        = 64;
	localparam int unsigned STATUS_W      = 2;
	localparam int unsigned OCC_W         = 7;

	localparam int unsigned FQ_DEPTH = 2;
	localparam int unsigned OQ_DEPTH = 4;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DUMP_FWD   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DUMP_BWD   = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_POP,
		OP_DUMP,
		OP_NOP
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic                at_back;
		logic [WORD_W-1:0]   value;
	} op_t;

	typedef struct packed {
		logic                from_ram;
		logic [STATUS_W-1:0] status;
		logic                last;
		logic [OCC_W-1:0]    occupancy;
	} res_ctl_t;

	typedef struct packed {
		logic [WORD_W-1:0]   word;
		logic [STATUS_W-1:0] status;
		logic                last;
		logic [OCC_W-1:0]    occupancy;
	} result_t;

endpackage

// File: rtl/core/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/deq_front.sv
// Command intake: decodes each command and buffers it for the execution side.
module deq_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [deq_pkg::CMD_W-1:0]   command,
	input  logic [deq_pkg::WORD_W-1:0]  value,
	output logic                        op_valid,
	output deq_pkg::op_t                op,
	input  logic                        op_take
);
	import deq_pkg::*;

	localparam int unsigned PW = $clog2(FQ_DEPTH);
	localparam int unsigned CW = $clog2(FQ_DEPTH + 1);

	op_t           fq_mem_q [FQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	op_t           dec_op;
	logic          wr_en;
	logic          rd_en;

	always_comb begin
		dec_op.value   = value;
		dec_op.at_back = 1'b0;
		dec_op.kind    = OP_NOP;
		unique case (command)
			CMD_PUSH_FRONT: begin
				dec_op.kind = OP_PUSH;
			end
			CMD_PUSH_BACK: begin
				dec_op.kind    = OP_PUSH;
				dec_op.at_back = 1'b1;
			end
			CMD_POP_FRONT: begin
				dec_op.kind = OP_POP;
			end
			CMD_POP_BACK: begin
				dec_op.kind    = OP_POP;
				dec_op.at_back = 1'b1;
			end
			CMD_DUMP_FWD: begin
				dec_op.kind = OP_DUMP;
			end
			CMD_DUMP_BWD: begin
				dec_op.kind    = OP_DUMP;
				dec_op.at_back = 1'b1;
			end
			default: begin
				dec_op.kind = OP_NOP;
			end
		endcase
	end

	assign full     = (cnt_q == CW'(FQ_DEPTH));
	assign op_valid = (cnt_q != '0);
	assign op       = fq_mem_q[rd_ptr_q];
	assign wr_en    = push && !full;
	assign rd_en    = op_take && op_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fq_mem_q[wr_ptr_q] <= dec_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(wr_en) - CW'(rd_en);
		end
	end

endmodule

// File: rtl/core/deq_back.sv
// Execution side: holds the ring pointers, runs commands on the store, queues results.
module deq_back #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          op_valid,
	input  deq_pkg::op_t                  op,
	output logic                          op_take,
	output logic                          empty,
	input  logic                          pop,
	output logic [deq_pkg::WORD_W-1:0]    word,
	output logic [deq_pkg::STATUS_W-1:0]  status,
	output logic                          last,
	output logic [deq_pkg::OCC_W-1:0]     occupancy
);
	import deq_pkg::*;

	localparam int unsigned AW     = $clog2(DEPTH);
	localparam int unsigned CW     = $clog2(DEPTH + 1);
	localparam int unsigned SW     = $clog2(2 * DEPTH);
	localparam int unsigned OQ_PW  = $clog2(OQ_DEPTH);
	localparam int unsigned OQ_CW  = $clog2(OQ_DEPTH + 1);
	localparam int unsigned OQ_SW  = OQ_CW + 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] step_slot(input logic [AW-1:0] s, input logic down);
		logic [AW-1:0] r;
		if (down) begin
			r = (s == '0) ? LAST_SLOT : s - AW'(1);
		end else begin
			r = (s == LAST_SLOT) ? '0 : s + AW'(1);
		end
		return r;
	endfunction

	logic [AW-1:0]    fi_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    dump_left_q;
	logic [AW-1:0]    dump_slot_q;
	logic             dump_back_q;
	logic             res_valid_s1;
	res_ctl_t         res_s1;
	result_t          oq_mem_q [OQ_DEPTH];
	logic [OQ_PW-1:0] oq_wr_q;
	logic [OQ_PW-1:0] oq_rd_q;
	logic [OQ_CW-1:0] oq_cnt_q;

	logic [AW-1:0]    fi_n;
	logic [CW-1:0]    cnt_n;
	logic [CW-1:0]    dump_left_n;
	logic [AW-1:0]    dump_slot_n;
	logic             dump_back_n;
	logic             res_valid;
	res_ctl_t         res;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [AW-1:0]    ram_raddr;
	logic [WORD_W-1:0] ram_rdata;
	logic [SW-1:0]    sum_tail;
	logic [SW-1:0]    sum_end;
	logic [AW-1:0]    tail_slot;
	logic [AW-1:0]    end_slot;
	logic [AW-1:0]    start_slot;
	logic             can_issue;
	logic             is_full;
	logic             is_empty;
	logic             oq_push;
	logic             oq_pop;
	result_t          oq_in;

	assign sum_tail  = SW'(fi_q) + SW'(cnt_q);
	assign sum_end   = sum_tail - SW'(1);
	assign tail_slot = (sum_tail >= SW'(DEPTH)) ? AW'(sum_tail - SW'(DEPTH)) : AW'(sum_tail);
	assign end_slot  = (sum_end >= SW'(DEPTH)) ? AW'(sum_end - SW'(DEPTH)) : AW'(sum_end);
	assign is_full   = (cnt_q == CW'(DEPTH));
	assign is_empty  = (cnt_q == '0);
	assign can_issue = (OQ_SW'(oq_cnt_q) + OQ_SW'(res_valid_s1)) < OQ_SW'(OQ_DEPTH);
	assign start_slot = op.at_back ? end_slot : fi_q;

	always_comb begin
		fi_n          = fi_q;
		cnt_n         = cnt_q;
		dump_left_n   = dump_left_q;
		dump_slot_n   = dump_slot_q;
		dump_back_n   = dump_back_q;
		op_take       = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = tail_slot;
		ram_raddr     = dump_slot_q;
		res_valid     = 1'b0;
		res.from_ram  = 1'b0;
		res.status    = ST_OK;
		res.last      = 1'b1;
		if (can_issue && dump_left_q != '0) begin
			res_valid    = 1'b1;
			res.from_ram = 1'b1;
			res.last     = (dump_left_q == CW'(1));
			dump_left_n  = dump_left_q - CW'(1);
			dump_slot_n  = step_slot(dump_slot_q, dump_back_q);
		end else if (can_issue && op_valid) begin
			op_take   = 1'b1;
			res_valid = 1'b1;
			unique case (op.kind)
				OP_PUSH: begin
					if (is_full) begin
						res.status = ST_FULL;
					end else begin
						ram_we = 1'b1;
						if (!op.at_back) begin
							fi_n      = step_slot(fi_q, 1'b1);
							ram_waddr = fi_n;
						end
						cnt_n = cnt_q + CW'(1);
					end
				end
				OP_POP: begin
					if (is_empty) begin
						res.status = ST_EMPTY;
					end else begin
						res.from_ram = 1'b1;
						ram_raddr    = start_slot;
						if (!op.at_back) begin
							fi_n = step_slot(fi_q, 1'b0);
						end
						cnt_n = cnt_q - CW'(1);
					end
				end
				OP_DUMP: begin
					if (is_empty) begin
						res.status = ST_EMPTY;
					end else begin
						res.from_ram = 1'b1;
						ram_raddr    = start_slot;
						res.last     = (cnt_q == CW'(1));
						dump_left_n  = cnt_q - CW'(1);
						dump_slot_n  = step_slot(start_slot, op.at_back);
						dump_back_n  = op.at_back;
					end
				end
				OP_NOP: begin
					res.status = ST_OK;
				end
				default: begin
					res.status = ST_OK;
				end
			endcase
		end
		res.occupancy = OCC_W'(cnt_n);
	end

	deq_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (op.value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		oq_in.word      = res_s1.from_ram ? ram_rdata : '0;
		oq_in.status    = res_s1.status;
		oq_in.last      = res_s1.last;
		oq_in.occupancy = res_s1.occupancy;
	end

	assign oq_push   = res_valid_s1;
	assign empty     = (oq_cnt_q == '0);
	assign oq_pop    = pop && !empty;
	assign word      = oq_mem_q[oq_rd_q].word;
	assign status    = oq_mem_q[oq_rd_q].status;
	assign last      = oq_mem_q[oq_rd_q].last;
	assign occupancy = oq_mem_q[oq_rd_q].occupancy;

	always_ff @(posedge clk) begin
		res_s1 <= res;
		if (oq_push) begin
			oq_mem_q[oq_wr_q] <= oq_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fi_q         <= '0;
			cnt_q        <= '0;
			dump_left_q  <= '0;
			dump_slot_q  <= '0;
			dump_back_q  <= 1'b0;
			res_valid_s1 <= 1'b0;
			oq_wr_q      <= '0;
			oq_rd_q      <= '0;
			oq_cnt_q     <= '0;
		end else begin
			fi_q         <= fi_n;
			cnt_q        <= cnt_n;
			dump_left_q  <= dump_left_n;
			dump_slot_q  <= dump_slot_n;
			dump_back_q  <= dump_back_n;
			res_valid_s1 <= res_valid;
			if (oq_push) begin
				oq_wr_q <= oq_wr_q + OQ_PW'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + OQ_PW'(1);
			end
			oq_cnt_q <= oq_cnt_q + OQ_CW'(oq_push) - OQ_CW'(oq_pop);
		end
	end

endmodule

// File: rtl/core/double_ended_queue.sv
// Top level of the bounded double-ended queue of 64-bit words.
// Throughput: one push, pop or unused command per cycle while the result
// queue has room; a dump of n entries gives n store reads, one per cycle,
// and later commands wait behind it.
// Reset clears the ring pointers, the entry count and both queues; the store
// itself is not cleared and holds no valid state until written.
module double_ended_queue #(
	parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [deq_pkg::CMD_W-1:0]     command,
	input  logic [deq_pkg::WORD_W-1:0]    value,
	output logic                          empty,
	input  logic                          pop,
	output logic [deq_pkg::WORD_W-1:0]    word,
	output logic [deq_pkg::STATUS_W-1:0]  status,
	output logic                          last,
	output logic [deq_pkg::OCC_W-1:0]     occupancy
);
	import deq_pkg::*;

	logic op_valid;
	op_t  op;
	logic op_take;

	deq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.command  (command),
		.value    (value),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take)
	);

	deq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.op_take   (op_take),
		.empty     (empty),
		.pop       (pop),
		.word      (word),
		.status    (status),
		.last      (last),
		.occupancy (occupancy)
	);

endmodule

// File: bench/tb_top.sv
// Self-checking bench for double_ended_queue: a directed command table, then random deque traffic.
`timescale 1ns / 100ps

module tb_top;
	import deq_pkg::*;

	localparam int RING = DEPTH_DEFAULT;
	localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
	localparam int HOLD_CYCLES = 200;
	localparam int TOTAL_ITEMS = 260;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [WORD_W-1:0] val;
		logic              typed;
		result_t           res;
	} row_t;

	localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

	localparam row_t DIRECTED [24] = '{
		'{CMD_POP_FRONT,  64'd0, 1'b1, '{64'd0, ST_EMPTY, 1'b1, 7'd0}},
		'{CMD_POP_BACK,   64'd0, 1'b1, '{64'd0, ST_EMPTY, 1'b1, 7'd0}},
		'{CMD_DUMP_FWD,   64'd0, 1'b1, '{64'd0, ST_EMPTY, 1'b1, 7'd0}},
		'{CMD_DUMP_BWD,   64'd0, 1'b1, '{64'd0, ST_EMPTY, 1'b1, 7'd0}},
		'{CMD_SPARE_6,    64'd0, 1'b1, '{64'd0, ST_OK,    1'b1, 7'd0}},
		'{CMD_SPARE_7,    ONES,  1'b1, '{64'd0, ST_OK,    1'b1, 7'd0}},
		'{CMD_PUSH_FRONT, ONES,  1'b1, '{64'd0, ST_OK,    1'b1, 7'd1}},
		'{CMD_PUSH_BACK,  64'd0, 1'b1, '{64'd0, ST_OK,    1'b1, 7'd2}},
		'{CMD_PUSH_FRONT, 64'h8000_0000_0000_0001, 1'b1, '{64'd0, ST_OK, 1'b1, 7'd3}},
		'{CMD_PUSH_BACK,  64'h5555_5555_5555_5555, 1'b1, '{64'd0, ST_OK, 1'b1, 7'd4}},
		'{CMD_PUSH_FRONT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{64'd0, ST_OK, 1'b1, 7'd5}},
		'{CMD_DUMP_FWD,   64'd0, 1'b0, '0},
		'{CMD_DUMP_BWD,   ONES,  1'b0, '0},
		'{CMD_POP_FRONT,  ONES,  1'b0, '0},
		'{CMD_POP_BACK,   64'd0, 1'b0, '0},
		'{CMD_SPARE_6,    ONES,  1'b1, '{64'd0, ST_OK,    1'b1, 7'd3}},
		'{CMD_POP_BACK,   64'd0, 1'b0, '0},
		'{CMD_POP_FRONT,  64'd0, 1'b0, '0},
		'{CMD_POP_FRONT,  64'd0, 1'b0, '0},
		'{CMD_POP_BACK,   ONES,  1'b1, '{64'd0, ST_EMPTY, 1'b1, 7'd0}},
		'{CMD_PUSH_BACK,  ONES,  1'b1, '{64'd0, ST_OK,    1'b1, 7'd1}},
		'{CMD_DUMP_BWD,   64'd0, 1'b0, '0},
		'{CMD_POP_FRONT,  64'd0, 1'b0, '0},
		'{CMD_DUMP_FWD,   64'd0, 1'b1, '{64'd0, ST_EMPTY, 1'b1, 7'd0}}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push;
	logic                full;
	logic [CMD_W-1:0]    command;
	logic [WORD_W-1:0]   value;
	logic                empty;
	logic                pop;
	logic [WORD_W-1:0]   word;
	logic [STATUS_W-1:0] status;
	logic                last;
	logic [OCC_W-1:0]    occupancy;

	logic [WORD_W-1:0] ring [RING];
	logic [5:0]        ring_head = '0;
	logic [OCC_W-1:0]  ring_count = '0;

	result_t cmd_results [$];
	result_t due_results [$];

	int  mismatches = 0;
	int  sent = 0;
	int  idle_pct = 0;
	bit  calm = 1'b0;
	bit  hold_pop = 1'b0;

	double_ended_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.word      (word),
		.status    (status),
		.last      (last),
		.occupancy (occupancy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void note(input logic [WORD_W-1:0] w, input logic [STATUS_W-1:0] st,
			input logic lst);
		result_t r;
		r.word      = w;
		r.status    = st;
		r.last      = lst;
		r.occupancy = ring_count;
		cmd_results.push_back(r);
	endfunction

	// advance the deque shadow by one command and collect the results it causes
	function automatic void predict_deque(input logic [CMD_W-1:0] cmd,
			input logic [WORD_W-1:0] val);
		logic [5:0] slot;
		cmd_results.delete();
		case (cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (ring_count == RING) begin
					note('0, ST_FULL, 1'b1);
				end else begin
					if (cmd == CMD_PUSH_FRONT) begin
						ring_head = ring_head - 6'd1;
						ring[ring_head] = val;
					end else begin
						slot = ring_head + ring_count[5:0];
						ring[slot] = val;
					end
					ring_count = ring_count + 7'd1;
					note('0, ST_OK, 1'b1);
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (ring_count == 0) begin
					note('0, ST_EMPTY, 1'b1);
				end else begin
					if (cmd == CMD_POP_FRONT) begin
						slot = ring_head;
						ring_head = ring_head + 6'd1;
					end else begin
						slot = ring_head + ring_count[5:0] - 6'd1;
					end
					ring_count = ring_count - 7'd1;
					note(ring[slot], ST_OK, 1'b1);
				end
			end
			CMD_DUMP_FWD, CMD_DUMP_BWD: begin
				if (ring_count == 0) begin
					note('0, ST_EMPTY, 1'b1);
				end else begin
					for (int i = 0; i < ring_count; i++) begin
						if (cmd == CMD_DUMP_FWD)
							slot = ring_head + 6'(i);
						else
							slot = ring_head + ring_count[5:0] - 6'd1 - 6'(i);
						note(ring[slot], ST_OK, (i + 1 == ring_count));
					end
				end
			end
			default: begin
				note('0, ST_OK, 1'b1);
			end
		endcase
	endfunction

	task automatic send(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] val,
			input logic typed, input result_t typed_res);
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		push    <= 1'b1;
		command <= cmd;
		value   <= val;
		do @(posedge clk); while (full);
		predict_deque(cmd, val);
		if (typed)
			due_results.push_back(typed_res);
		else
			foreach (cmd_results[i]) due_results.push_back(cmd_results[i]);
		sent++;
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 5))
			0: return ONES;
			1: return '0;
			2: return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] rand_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 22) return CMD_PUSH_FRONT;
		if (r < 44) return CMD_PUSH_BACK;
		if (r < 62) return CMD_POP_FRONT;
		if (r < 80) return CMD_POP_BACK;
		if (r < 87) return CMD_DUMP_FWD;
		if (r < 94) return CMD_DUMP_BWD;
		if (r < 97) return CMD_SPARE_6;
		return CMD_SPARE_7;
	endfunction

	task automatic mix(input int n);
		repeat (n) send(rand_cmd(), rand_word(), 1'b0, '0);
	endtask

	initial begin
		push    <= 1'b0;
		command <= CMD_PUSH_FRONT;
		value   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) send(DIRECTED[i].cmd, DIRECTED[i].val, DIRECTED[i].typed,
			DIRECTED[i].res);

		idle_pct = 30;
		mix(40);
		idle_pct = 0;
		mix(15);

		// fill to capacity with the output side held off, then overflow
		hold_pop = 1'b1;
		while (ring_count != RING)
			send($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, rand_word(), 1'b0, '0);
		repeat (3)
			send($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, rand_word(), 1'b0, '0);
		idle_pct = 20;
		send(CMD_DUMP_FWD, rand_word(), 1'b0, '0);
		send(CMD_DUMP_BWD, rand_word(), 1'b0, '0);
		mix(20);

		// drain to empty, then underflow
		while (ring_count != 0)
			send($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, rand_word(), 1'b0, '0);
		repeat (2)
			send($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, rand_word(), 1'b0, '0);

		calm = 1'b1;
		mix((sent < TOTAL_ITEMS - 30) ? TOTAL_ITEMS - sent : 30);
		push <= 1'b0;

		while (due_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	initial begin
		int stall;
		stall = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pop) begin
				hold_pop = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
				pop <= 1'b0;
				stall = $urandom_range(0, 2);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && pop && !empty) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected transaction, word %h status %0d last %0d occupancy %0d",
					$time, word, status, last, occupancy);
				mismatches++;
			end else begin
				exp_res = due_results.pop_front();
				if (word !== exp_res.word) begin
					$display("%0t: word expected %h, actual %h", $time, exp_res.word, word);
					mismatches++;
				end
				if (status !== exp_res.status) begin
					$display("%0t: status expected %0d, actual %0d", $time, exp_res.status, status);
					mismatches++;
				end
				if (last !== exp_res.last) begin
					$display("%0t: last expected %0d, actual %0d", $time, exp_res.last, last);
					mismatches++;
				end
				if (occupancy !== exp_res.occupancy) begin
					$display("%0t: occupancy expected %0d, actual %0d", $time,
						exp_res.occupancy, occupancy);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_front.sv
rtl/core/deq_back.sv
rtl/core/double_ended_queue.sv
bench/tb_top.sv
